// ===== sv/calendar_to_epoch_seconds_top_macros.svh =====
`ifndef CALENDAR_TO_EPOCH_SECONDS_TOP_MACROS_SVH
`define CALENDAR_TO_EPOCH_SECONDS_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define C2E_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define C2E_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/c2e_pkg.sv =====
`timescale 1ns / 1ps

package c2e_pkg;

	localparam logic [11:0] YEAR_BASE    = 12'd1970;
	localparam logic [11:0] LEAPS_BASE   = 12'd477;
	localparam logic [12:0] RECIP_100    = 13'd5243;
	localparam int          RECIP_SHIFT  = 19;
	localparam logic [6:0]  CENTURY      = 7'd100;
	localparam logic [8:0]  DAYS_YEAR    = 9'd365;
	localparam logic [3:0]  MONTH_FEB    = 4'd2;
	localparam logic [11:0] SECS_HOUR    = 12'd3600;
	localparam logic [5:0]  SECS_MINUTE  = 6'd60;
	localparam logic [16:0] SECS_DAY     = 17'd86400;

	typedef logic [16:0] tod_t;
	typedef logic [31:0] days_t;

	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			4'd13:   d = 9'd365;
			4'd14:   d = 9'd396;
			default: d = 9'd427;
		endcase
		return d;
	endfunction

endpackage

// ===== sv/c2e_days.sv =====
`timescale 1ns / 1ps

module c2e_days
	import c2e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	output logic        valid_s3,
	output days_t       days_s3,
	output tod_t        tod_s3
);

	`include "calendar_to_epoch_seconds_top_macros.svh"

	// stage 1: reciprocal quotients by 100 and time-of-day products
	logic        valid_s1;
	logic [11:0] year_s1;
	logic [11:0] ym1_s1;
	logic [11:0] ydiff_s1;
	logic        gt_s1;
	logic [5:0]  q100y_s1;
	logic [5:0]  q100m1_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [16:0] hs_s1;
	logic [11:0] ms_s1;
	logic [5:0]  sec_s1;

	logic [11:0] ym1;
	logic [24:0] prod_y;
	logic [24:0] prod_m1;

	assign ym1     = year - 12'd1;
	assign prod_y  = 25'(year * RECIP_100);
	assign prod_m1 = 25'(ym1 * RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s1   <= year;
			ym1_s1    <= ym1;
			ydiff_s1  <= year - YEAR_BASE;
			gt_s1     <= (year > YEAR_BASE);
			q100y_s1  <= prod_y[RECIP_SHIFT +: 6];
			q100m1_s1 <= prod_m1[RECIP_SHIFT +: 6];
			month_s1  <= month;
			day_s1    <= day;
			hs_s1     <= 17'(hour * SECS_HOUR);
			ms_s1     <= 12'(minute * SECS_MINUTE);
			sec_s1    <= second;
		end
	end

	// stage 2: whole-year days, month days with leap fix, time of day
	logic        valid_s2;
	logic [19:0] ydays_s2;
	logic [8:0]  mdays_s2;
	logic [4:0]  day_s2;
	tod_t        tod_s2;

	logic [11:0] leaps;
	logic [12:0] cent;
	logic        rem0;
	logic        leap;

	assign leaps = {2'b00, ym1_s1[11:2]} - {6'b0, q100m1_s1}
		+ {8'b0, q100m1_s1[5:2]} - LEAPS_BASE;
	assign cent  = 13'(q100y_s1 * CENTURY);
	assign rem0  = ({1'b0, year_s1} == cent);
	assign leap  = ((year_s1[1:0] == 2'b00) && !rem0) || (rem0 && (q100y_s1[1:0] == 2'b00));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ydays_s2 <= gt_s1 ? 20'(ydiff_s1 * DAYS_YEAR) + {8'b0, leaps} : 20'd0;
			mdays_s2 <= days_before_month(month_s1)
				+ {8'b0, (month_s1 > MONTH_FEB) && leap};
			day_s2   <= day_s1;
			tod_s2   <= hs_s1 + {5'b0, ms_s1} + {11'b0, sec_s1};
		end
	end

	// stage 3: total day count, modulo 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			days_s3 <= {12'b0, ydays_s2} + {23'b0, mdays_s2} + {27'b0, day_s2} - 32'd1;
			tod_s3  <= tod_s2;
		end
	end

	`C2E_ASSERT_NEXT(a_s1_load, en, valid_s1 == $past(in_valid), "stage 1 valid lost")
	`C2E_ASSERT_NEXT(a_hold_s3, !en, $stable(valid_s3) && $stable(days_s3), "stage 3 moved on stall")

endmodule

// ===== sv/c2e_secs.sv =====
`timescale 1ns / 1ps

module c2e_secs
	import c2e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid_s3,
	input  days_t       days_s3,
	input  tod_t        tod_s3,
	output logic        valid_s4,
	output logic [31:0] secs_s4
);

	`include "calendar_to_epoch_seconds_top_macros.svh"

	logic [31:0] day_secs;

	assign day_secs = 32'(days_s3 * SECS_DAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			secs_s4 <= day_secs + {15'b0, tod_s3};
		end
	end

	`C2E_ASSERT_NEXT(a_s4_load, en, valid_s4 == $past(valid_s3), "output stage valid lost")

endmodule

// ===== sv/calendar_to_epoch_seconds_top.sv =====
// accepted input beats pass stages s1, s2, s3 and s4 to the result, one beat
// per cycle unless stalled; four register stages share one advance enable
// a stall on the result side holds every stage and drops input ready
// reset: asynchronous active-low arst_n clears all stage valid bits
`timescale 1ns / 1ps

module calendar_to_epoch_seconds_top
	import c2e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] epoch_seconds
);

	`include "calendar_to_epoch_seconds_top_macros.svh"

	logic  en;
	logic  valid_s3;
	days_t days_s3;
	tod_t  tod_s3;

	assign en         = !result_valid || result_ready;
	assign item_ready = en;

	c2e_days u_days (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (item_valid),
		.year     (year),
		.month    (month),
		.day      (day),
		.hour     (hour),
		.minute   (minute),
		.second   (second),
		.valid_s3 (valid_s3),
		.days_s3  (days_s3),
		.tod_s3   (tod_s3)
	);

	c2e_secs u_secs (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s3 (valid_s3),
		.days_s3  (days_s3),
		.tod_s3   (tod_s3),
		.valid_s4 (result_valid),
		.secs_s4  (epoch_seconds)
	);

	`C2E_ASSERT_NOW(a_stall_blocks, result_valid && !result_ready, !item_ready, "input taken during stall")
	`C2E_ASSERT_NOW(a_empty_ready, !result_valid, item_ready, "empty output but input blocked")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import c2e_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BEATS_PER_PHASE = 332;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} calendar_beat_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic        result_valid;
	logic        result_ready;
	logic [31:0] epoch_seconds;

	calendar_beat_t dates_to_send[$];
	logic [31:0]    epoch_due[$];
	int             send_idle_pct;
	int             recv_stall_pct;
	int             mismatch_count;
	int             cycle_count;
	bit             item_taken;

	calendar_to_epoch_seconds_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.year(year),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.epoch_seconds(epoch_seconds)
	);

	function automatic bit is_leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// leap years among years 1..n
	function automatic int unsigned leap_count(input int unsigned n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	function automatic logic [31:0] unix_seconds_of(input calendar_beat_t b);
		int unsigned y;
		int unsigned m;
		int unsigned total_days;
		int unsigned month_start[16];
		month_start = '{0, 0, 31, 59, 90, 120, 151, 181,
			212, 243, 273, 304, 334, 365, 396, 427};
		y = b.year;
		m = b.month;
		total_days = 0;
		if (y > 1970)
			total_days = 365 * (y - 1970) + leap_count(y - 1) - leap_count(1969);
		total_days += month_start[m];
		if (m > 2 && is_leap_year(y))
			total_days += 1;
		total_days += int'(unsigned'(b.day)) - 1;
		return total_days * 86400 + int'(unsigned'(b.hour)) * 3600
			+ int'(unsigned'(b.minute)) * 60 + int'(unsigned'(b.second));
	endfunction

	function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
		case (m)
			4, 6, 9, 11: return 30;
			2:           return is_leap_year(y) ? 29 : 28;
			default:     return 31;
		endcase
	endfunction

	function automatic calendar_beat_t random_date();
		calendar_beat_t b;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 85) begin
			case ($urandom_range(9))
				0:       b.year = YEAR_BASE;
				1:       b.year = 12'd2105;
				2:       b.year = 12'd2000;
				3:       b.year = 12'd2100;
				default: b.year = 12'($urandom_range(1970, 2105));
			endcase
			b.month  = 4'($urandom_range(1, 12));
			b.day    = 5'($urandom_range(1, month_length(b.year, b.month)));
			b.hour   = 5'($urandom_range(0, 23));
			b.minute = 6'($urandom_range(0, 59));
			b.second = 6'($urandom_range(0, 59));
		end else begin
			b = calendar_beat_t'({$urandom, 6'($urandom)});
			b.year = 12'($urandom);
		end
		return b;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic queue_date(input int y, input int m, input int d, input int h,
			input int mi, input int s);
		calendar_beat_t b;
		b.year   = 12'(y);
		b.month  = 4'(m);
		b.day    = 5'(d);
		b.hour   = 5'(h);
		b.minute = 6'(mi);
		b.second = 6'(s);
		dates_to_send.push_back(b);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor: accepted beats feed the prediction, result beats are checked
	always @(posedge clk) begin
		logic [31:0] want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_top NOT OK");
			$finish;
		end else if (!arst_n) begin
			item_taken = 1'b0;
		end else begin
			item_taken = item_valid && item_ready;
			if (item_taken)
				epoch_due.push_back(unix_seconds_of({year, month, day, hour, minute, second}));
			if (result_valid && result_ready) begin
				if (epoch_due.size() == 0) begin
					report_mismatch("result beat with nothing pending", epoch_seconds, '0);
				end else begin
					want = epoch_due.pop_front();
					if (epoch_seconds !== want)
						report_mismatch("epoch_seconds", epoch_seconds, want);
				end
			end
		end
	end

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		calendar_beat_t b;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (dates_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				b = dates_to_send.pop_front();
				year       <= b.year;
				month      <= b.month;
				day        <= b.day;
				hour       <= b.hour;
				minute     <= b.minute;
				second     <= b.second;
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
		result_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		result_ready   = 1'b0;
		year           = '0;
		month          = '0;
		day            = '0;
		hour           = '0;
		minute         = '0;
		second         = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		item_taken     = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 73;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 73;
				end
				default: begin
					send_idle_pct = 10;
					recv_stall_pct = 10;
				end
			endcase
			if (phase == 0) begin
				queue_date(1970, 1, 1, 0, 0, 0);
				queue_date(2105, 12, 31, 23, 59, 59);
				queue_date(1972, 2, 29, 6, 30, 0);
				queue_date(2000, 2, 29, 12, 0, 0);
				queue_date(2000, 3, 1, 0, 0, 0);
				queue_date(2100, 2, 28, 23, 59, 59);
				queue_date(2100, 3, 1, 0, 0, 0);
				queue_date(2004, 12, 31, 1, 2, 3);
				queue_date(1999, 12, 31, 23, 59, 59);
				queue_date(2038, 1, 19, 3, 14, 8);
				// years before the epoch
				queue_date(1969, 6, 15, 10, 20, 30);
				queue_date(0, 3, 1, 0, 0, 0);
				// month zero and months past december
				queue_date(2024, 0, 10, 0, 0, 0);
				queue_date(2023, 13, 1, 0, 0, 0);
				queue_date(2024, 14, 5, 8, 0, 0);
				queue_date(2025, 15, 31, 0, 0, 1);
				// day zero, including the wrap below zero
				queue_date(2020, 5, 0, 0, 0, 0);
				queue_date(1970, 1, 0, 0, 0, 0);
				// fields past their calendar range and years past 2105
				queue_date(2050, 7, 31, 31, 63, 63);
				queue_date(2106, 2, 7, 6, 28, 16);
				queue_date(4095, 15, 31, 31, 63, 63);
				queue_date(2048, 8, 16, 16, 32, 32);
			end
			for (int i = 0; i < RANDOM_BEATS_PER_PHASE; i++)
				dates_to_send.push_back(random_date());
			do begin
				@(posedge clk);
				#1;
			end while (dates_to_send.size() != 0 || item_valid || epoch_due.size() != 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		#1;
		if (epoch_due.size() != 0)
			report_mismatch("results never seen", epoch_due.size(), 0);
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
